// ----- hdl/uhe_pkg.sv -----
package uhe_pkg;

  typedef enum logic [1:0] {
    CMD_CTRL     = 2'd0,
    CMD_BUF_CTRL = 2'd1,
    CMD_PACKET   = 2'd2,
    CMD_SETUP_HS = 2'd3
  } cmd_t;

  localparam logic [1:0] HS_ACK   = 2'd0;
  localparam logic [1:0] HS_NAK   = 2'd1;
  localparam logic [1:0] HS_STALL = 2'd2;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_NEXT  = 2'd1;
  localparam logic [1:0] ACT_RETRY = 2'd2;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_VAL_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_BUFFERED       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IRQ_PER_BUFFER        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IRQ_PER_DOUBLE_BUFFER = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BLOCK          = 4'd3;

  localparam int BC_FULL_BIT  = 15;
  localparam int BC_LAST_BIT  = 14;
  localparam int BC_AVAIL_BIT = 10;
  localparam int LEN_W        = 10;
  localparam int ADDR_W       = 17;
  localparam int BLOCK_SHIFT  = 6;

  typedef struct packed {
    cmd_t        command;
    logic [6:0]  dev_addr;
    logic [3:0]  endpoint;
    logic        start_xfer;
    logic        send_setup;
    logic        receive_data;
    logic        bus_reset_req;
    logic [31:0] buf_ctrl_word;
    logic [1:0]  handshake;
    logic        device_present;
    logic [9:0]  received_len;
  } in_item_t;

  typedef struct packed {
    logic [31:0] buf_ctrl_out;
    logic        active;
    logic        trans_complete;
    logic        stall_received;
    logic        ack_received;
    logic        rx_timeout;
    logic        buffer_status;
    logic [1:0]  packet_action;
    logic [16:0] data_addr;
    logic [9:0]  transfer_len;
    logic        setup_request;
    logic        bus_reset_pulse;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic      step_en;
    logic      cfg_we;
    cfg_word_t cfg;
  } step_ctl_t;

endpackage

// ----- hdl/uhe_stream_if.sv -----
interface uhe_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/uhe_step.sv -----
module uhe_step #(
  parameter int HALF_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  uhe_pkg::step_ctl_t ctl,
  input  uhe_pkg::in_item_t  item,
  output uhe_pkg::out_item_t result
);

  localparam logic [uhe_pkg::ADDR_W-1:0] HalfOffset = uhe_pkg::ADDR_W'(HALF_BYTES);

  logic        double_buffered_r;
  logic        irq_per_buffer_r;
  logic        irq_per_double_buffer_r;
  logic [9:0]  buffer_block_r;

  logic        xfer_active_r, xfer_active_nxt;
  logic        dir_in_r, dir_in_nxt;
  logic        cur_half_r, cur_half_nxt;
  logic [6:0]  target_addr_r, target_addr_nxt;
  logic [3:0]  target_ep_r, target_ep_nxt;
  logic [31:0] buffer_control_r, buffer_control_nxt;
  logic        done_r, done_nxt;
  logic        stall_r, stall_nxt;
  logic        ack_r, ack_nxt;
  logic        timeout_r, timeout_nxt;
  logic        buff_flag_r, buff_flag_nxt;

  logic [1:0]  action;
  logic [16:0] daddr;
  logic [9:0]  tlen;
  logic        setup_req;
  logic        bus_rst;

  logic        half;
  logic [15:0] buf_half;
  logic [15:0] buf_new;
  logic [9:0]  len;
  logic [9:0]  clamped;
  logic        shortp;
  logic        last;
  logic        per_double;

  always_comb begin
    half     = double_buffered_r & cur_half_r;
    buf_half = half ? buffer_control_r[31:16] : buffer_control_r[15:0];
    len      = buf_half[uhe_pkg::LEN_W-1:0];
    shortp   = item.received_len < len;
    clamped  = shortp ? item.received_len : len;
    buf_new  = buf_half;
    if (dir_in_r) begin
      buf_new[uhe_pkg::BC_AVAIL_BIT] = 1'b0;
      buf_new[uhe_pkg::LEN_W-1:0]    = clamped;
      buf_new[uhe_pkg::BC_FULL_BIT]  = 1'b1;
    end else begin
      buf_new[uhe_pkg::BC_AVAIL_BIT] = 1'b0;
      buf_new[uhe_pkg::BC_FULL_BIT]  = 1'b0;
    end
    last       = buf_new[uhe_pkg::BC_LAST_BIT] | (dir_in_r & shortp);
    per_double = double_buffered_r & irq_per_double_buffer_r & ~irq_per_buffer_r;
  end

  always_comb begin
    xfer_active_nxt    = xfer_active_r;
    dir_in_nxt         = dir_in_r;
    cur_half_nxt       = cur_half_r;
    target_addr_nxt    = target_addr_r;
    target_ep_nxt      = target_ep_r;
    buffer_control_nxt = buffer_control_r;
    done_nxt           = done_r;
    stall_nxt          = stall_r;
    ack_nxt            = ack_r;
    timeout_nxt        = timeout_r;
    buff_flag_nxt      = buff_flag_r;
    action             = uhe_pkg::ACT_NONE;
    daddr              = '0;
    tlen               = '0;
    setup_req          = 1'b0;
    bus_rst            = 1'b0;

    case (item.command)
      uhe_pkg::CMD_CTRL: begin
        bus_rst = item.bus_reset_req & item.device_present;
        if (item.start_xfer) begin
          if (item.send_setup) begin
            xfer_active_nxt = 1'b0;
            setup_req       = 1'b1;
          end else begin
            xfer_active_nxt = 1'b1;
            dir_in_nxt      = item.receive_data;
            cur_half_nxt    = 1'b0;
            target_addr_nxt = item.dev_addr;
            target_ep_nxt   = item.endpoint;
            action          = uhe_pkg::ACT_NEXT;
          end
        end
      end
      uhe_pkg::CMD_BUF_CTRL: begin
        buffer_control_nxt = item.buf_ctrl_word;
        if (xfer_active_r) begin
          action = uhe_pkg::ACT_NEXT;
        end
      end
      uhe_pkg::CMD_SETUP_HS: begin
        if (!item.device_present) begin
          timeout_nxt = 1'b1;
        end else if (item.handshake == uhe_pkg::HS_STALL) begin
          stall_nxt = 1'b1;
        end else begin
          done_nxt = 1'b1;
          ack_nxt  = 1'b1;
        end
      end
      uhe_pkg::CMD_PACKET: begin
        if (xfer_active_r && item.device_present && buf_half[uhe_pkg::BC_AVAIL_BIT]) begin
          daddr = (uhe_pkg::ADDR_W'(buffer_block_r) << uhe_pkg::BLOCK_SHIFT) +
                  (half ? HalfOffset : '0);
          if (item.handshake == uhe_pkg::HS_NAK) begin
            action = uhe_pkg::ACT_RETRY;
          end else if (item.handshake == uhe_pkg::HS_STALL) begin
            xfer_active_nxt = 1'b0;
            stall_nxt       = 1'b1;
          end else begin
            tlen = dir_in_r ? clamped : len;
            if (half) begin
              buffer_control_nxt[31:16] = buf_new;
            end else begin
              buffer_control_nxt[15:0] = buf_new;
            end
            if (!per_double || half || last) begin
              buff_flag_nxt = 1'b1;
            end
            if (last) begin
              xfer_active_nxt = 1'b0;
              done_nxt        = 1'b1;
            end else begin
              if (double_buffered_r) begin
                cur_half_nxt = ~cur_half_r;
              end
              action = uhe_pkg::ACT_NEXT;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.buf_ctrl_out    = buffer_control_nxt;
    result.active          = xfer_active_nxt;
    result.trans_complete  = done_nxt;
    result.stall_received  = stall_nxt;
    result.ack_received    = ack_nxt;
    result.rx_timeout      = timeout_nxt;
    result.buffer_status   = buff_flag_nxt;
    result.packet_action   = action;
    result.data_addr       = daddr;
    result.transfer_len    = tlen;
    result.setup_request   = setup_req;
    result.bus_reset_pulse = bus_rst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      double_buffered_r       <= 1'b0;
      irq_per_buffer_r        <= 1'b0;
      irq_per_double_buffer_r <= 1'b0;
      buffer_block_r          <= '0;
    end else if (ctl.cfg_we) begin
      case (ctl.cfg.index)
        uhe_pkg::REG_DOUBLE_BUFFERED:       double_buffered_r       <= ctl.cfg.value[0];
        uhe_pkg::REG_IRQ_PER_BUFFER:        irq_per_buffer_r        <= ctl.cfg.value[0];
        uhe_pkg::REG_IRQ_PER_DOUBLE_BUFFER: irq_per_double_buffer_r <= ctl.cfg.value[0];
        uhe_pkg::REG_BUFFER_BLOCK:          buffer_block_r          <= ctl.cfg.value;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xfer_active_r    <= 1'b0;
      dir_in_r         <= 1'b0;
      cur_half_r       <= 1'b0;
      target_addr_r    <= '0;
      target_ep_r      <= '0;
      buffer_control_r <= '0;
      done_r           <= 1'b0;
      stall_r          <= 1'b0;
      ack_r            <= 1'b0;
      timeout_r        <= 1'b0;
      buff_flag_r      <= 1'b0;
    end else if (ctl.step_en) begin
      xfer_active_r    <= xfer_active_nxt;
      dir_in_r         <= dir_in_nxt;
      cur_half_r       <= cur_half_nxt;
      target_addr_r    <= target_addr_nxt;
      target_ep_r      <= target_ep_nxt;
      buffer_control_r <= buffer_control_nxt;
      done_r           <= done_nxt;
      stall_r          <= stall_nxt;
      ack_r            <= ack_nxt;
      timeout_r        <= timeout_nxt;
      buff_flag_r      <= buff_flag_nxt;
    end
  end

  a_done_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("transaction complete flag dropped");

  a_stall_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    stall_r |=> stall_r)
    else $error("stall flag dropped");

  a_buff_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    buff_flag_r |=> buff_flag_r)
    else $error("buffer status flag dropped");

  // The endpoint target is held until a data transfer starts.
  a_target_held : assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.step_en && item.command == uhe_pkg::CMD_CTRL && item.start_xfer &&
      !item.send_setup) |=> $stable({target_addr_r, target_ep_r}))
    else $error("endpoint target changed outside a transfer start");

endmodule

// ----- hdl/usb_host_epx_transaction_engine.sv -----
// USB host EPX transfer sequencer.
// Words arrive on in_ch: control writes, buffer-control writes, packet slots
// and setup handshakes. Each accepted word yields exactly one result word on
// out_ch, carrying the buffer control word, the sticky status flags and the
// action for the bus scheduler. Configuration registers are written through
// cfg_ch, which is always ready; writes are expected only while the block is
// idle.
// An accepted word is held in an input register; its result is then computed
// from the endpoint state and loaded into the output register as soon as that
// register is free or being read. One word is taken every cycle when the
// receiver keeps out_ch.ready high.
// When the receiver stalls, the result waits in the output register, one
// further word may still be taken into the input register, and in_ch.ready
// then drops until the output register drains.
// A synchronous reset (rst_n low) empties both registers, clears all state
// and flags and returns the configuration registers to zero.
module usb_host_epx_transaction_engine #(
  parameter int HALF_BYTES = 64
) (
  input  logic clk,
  input  logic rst_n,
  uhe_stream_if.sink   in_ch,
  uhe_stream_if.source out_ch,
  uhe_stream_if.sink   cfg_ch
);

  logic                 in_valid_r;
  uhe_pkg::in_item_t    in_item_r;
  logic                 out_valid_r;
  uhe_pkg::out_item_t   out_item_r;
  uhe_pkg::out_item_t   result;
  uhe_pkg::step_ctl_t   ctl;
  logic                 advance;
  logic                 fire;

  assign advance      = !out_valid_r || out_ch.ready;
  assign fire         = in_valid_r && advance;
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign ctl.step_en = fire;
  assign ctl.cfg_we  = cfg_ch.valid;
  assign ctl.cfg     = cfg_ch.data;

  uhe_step #(
    .HALF_BYTES(HALF_BYTES)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .item   (in_item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  a_fire_loads : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("computed result not loaded into output register");

  a_held_word : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r)
    else $error("waiting input word lost");

  a_retry_active : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.packet_action == uhe_pkg::ACT_RETRY |-> out_item_r.active)
    else $error("retry requested on an inactive transfer");

  a_setup_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.setup_request |-> !out_item_r.active)
    else $error("setup stage started with a data transfer still active");

endmodule
